>>> hw/rtl/pvc_pkg.sv
package pvc_pkg;

    localparam logic [31:0] LIM_1B = 32'h0000_007f;
    localparam logic [31:0] LIM_2B = 32'h0000_3fff;
    localparam logic [31:0] LIM_3B = 32'h001f_ffff;
    localparam logic [31:0] LIM_4B = 32'h0fff_ffff;

    localparam logic [7:0] LEAD_2B = 8'h80;
    localparam logic [7:0] LEAD_3B = 8'hc0;
    localparam logic [7:0] LEAD_4B = 8'he0;
    localparam logic [7:0] LEAD_5B = 8'hf0;

    localparam logic MODE_ENC = 1'b0;
    localparam logic MODE_DEC = 1'b1;

    typedef struct packed {
        logic        emit;
        logic [31:0] value;
        logic [2:0]  len;
    } t_dec_res;

    function automatic logic [2:0] enc_len(input logic [31:0] v);
        logic [2:0] n;
        if (v <= LIM_1B) begin
            n = 3'd1;
        end else if (v <= LIM_2B) begin
            n = 3'd2;
        end else if (v <= LIM_3B) begin
            n = 3'd3;
        end else if (v <= LIM_4B) begin
            n = 3'd4;
        end else begin
            n = 3'd5;
        end
        return n;
    endfunction

    // byte idx (0 = lead) of an n-byte code
    function automatic logic [7:0] enc_byte(input logic [31:0] v, input logic [2:0] n,
                                            input logic [2:0] idx);
        logic [7:0] b;
        logic [2:0] sel;
        sel = n - 3'd1 - idx;
        if (idx == 3'd0) begin
            case (n)
                3'd1:    b = v[7:0];
                3'd2:    b = LEAD_2B | {2'b00, v[13:8]};
                3'd3:    b = LEAD_3B | {3'b000, v[20:16]};
                3'd4:    b = LEAD_4B | {4'h0, v[27:24]};
                default: b = LEAD_5B;
            endcase
        end else begin
            case (sel)
                3'd0:    b = v[7:0];
                3'd1:    b = v[15:8];
                3'd2:    b = v[23:16];
                default: b = v[31:24];
            endcase
        end
        return b;
    endfunction

endpackage

>>> hw/rtl/pvc_dec.sv
module pvc_dec (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    output pvc_pkg::t_dec_res o_res
);

    logic [2:0]  r_bytes_left, n_bytes_left;
    logic [31:0] r_partial,    n_partial;
    logic [2:0]  r_dec_len,    n_dec_len;
    logic [31:0] shifted;

    assign shifted = {r_partial[23:0], i_byte};

    always_comb begin
        n_bytes_left = r_bytes_left;
        n_partial    = r_partial;
        n_dec_len    = r_dec_len;
        o_res.emit   = 1'b0;
        o_res.value  = 32'd0;
        o_res.len    = 3'd1;
        if (r_bytes_left == 3'd0) begin
            if (!i_byte[7]) begin
                o_res.emit  = 1'b1;
                o_res.value = {24'd0, i_byte};
                o_res.len   = 3'd1;
            end else begin
                if (!i_byte[6]) begin
                    n_partial = {26'd0, i_byte[5:0]};
                    n_dec_len = 3'd2;
                end else if (!i_byte[5]) begin
                    n_partial = {27'd0, i_byte[4:0]};
                    n_dec_len = 3'd3;
                end else if (!i_byte[4]) begin
                    n_partial = {28'd0, i_byte[3:0]};
                    n_dec_len = 3'd4;
                end else begin
                    n_partial = 32'd0;
                    n_dec_len = 3'd5;
                end
                n_bytes_left = n_dec_len - 3'd1;
            end
        end else begin
            n_partial    = shifted;
            n_bytes_left = r_bytes_left - 3'd1;
            if (r_bytes_left == 3'd1) begin
                o_res.emit  = 1'b1;
                o_res.value = shifted;
                o_res.len   = r_dec_len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left <= 3'd0;
            r_partial    <= 32'd0;
            r_dec_len    <= 3'd0;
        end else if (i_step) begin
            r_bytes_left <= n_bytes_left;
            r_partial    <= n_partial;
            r_dec_len    <= n_dec_len;
        end
    end

endmodule

>>> hw/rtl/prefix_varint_codec.sv
// Channel  Dir  Handshake                 Payload
// cfg      in   i_cfg_we                  i_cfg_wdata (direction_mode)
// in       in   i_in_valid / o_in_stall   i_value_in, i_byte_in
// out      out  o_out_valid / i_out_stall o_byte_out, o_last_byte, o_value_out, o_code_length
//
// Decode: one byte a cycle unless the output stalls a completing byte; the result
// passes the input register, then the output register. Encode: a code stays in the
// input register while its bytes drain one per unstalled cycle; the next value enters as the last byte leaves.
// Output register takes a new beat whenever it is empty or being taken.
// Reset is synchronous; it clears the mode, decode state and both valid flags.
module prefix_varint_codec (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_value_in,
    input  logic [7:0]  i_byte_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_byte_out,
    output logic        o_last_byte,
    output logic [31:0] o_value_out,
    output logic [2:0]  o_code_length
);

    logic        r_dir;
    logic        r_busy;
    logic        r_mode;
    logic [31:0] r_val;
    logic [2:0]  r_len;
    logic [2:0]  r_idx;
    logic        r_ovalid;
    logic [7:0]  r_obyte;
    logic        r_olast;
    logic [31:0] r_ovalue;
    logic [2:0]  r_olen;

    pvc_pkg::t_dec_res dec_res;
    logic              out_free;
    logic              enc_last;
    logic              emit;
    logic              fire;
    logic              stage_done;
    logic              dec_step;
    logic              in_take;

    pvc_dec u_dec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (dec_step),
        .i_byte  (r_val[7:0]),
        .o_res   (dec_res)
    );

    always_comb begin
        out_free   = !r_ovalid || !i_out_stall;
        enc_last   = (r_idx == (r_len - 3'd1));
        emit       = r_busy && ((r_mode == pvc_pkg::MODE_DEC) ? dec_res.emit : 1'b1);
        fire       = emit && out_free;
        dec_step   = r_busy && (r_mode == pvc_pkg::MODE_DEC) && (!dec_res.emit || out_free);
        stage_done = r_busy && ((r_mode == pvc_pkg::MODE_DEC) ? (!dec_res.emit || out_free)
                                                              : (out_free && enc_last));
        in_take    = i_in_valid && (!r_busy || stage_done);
        o_in_stall = r_busy && !stage_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir    <= pvc_pkg::MODE_ENC;
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_dir <= i_cfg_wdata;
            end
            if (in_take) begin
                r_busy <= 1'b1;
            end else if (stage_done) begin
                r_busy <= 1'b0;
            end
            if (fire) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_mode <= r_dir;
            r_val  <= (r_dir == pvc_pkg::MODE_DEC) ? {24'd0, i_byte_in} : i_value_in;
            r_len  <= pvc_pkg::enc_len(i_value_in);
            r_idx  <= 3'd0;
        end else if (fire && (r_mode == pvc_pkg::MODE_ENC)) begin
            r_idx <= r_idx + 3'd1;
        end
        if (fire) begin
            if (r_mode == pvc_pkg::MODE_DEC) begin
                r_obyte  <= 8'd0;
                r_olast  <= 1'b0;
                r_ovalue <= dec_res.value;
                r_olen   <= dec_res.len;
            end else begin
                r_obyte  <= pvc_pkg::enc_byte(r_val, r_len, r_idx);
                r_olast  <= enc_last;
                r_ovalue <= 32'd0;
                r_olen   <= r_len;
            end
        end
    end

    assign o_out_valid   = r_ovalid;
    assign o_byte_out    = r_obyte;
    assign o_last_byte   = r_olast;
    assign o_value_out   = r_ovalue;
    assign o_code_length = r_olen;

endmodule

>>> hw/rtl/pvc_checker.sv
module pvc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [7:0]  o_byte_out,
    input logic        o_last_byte,
    input logic [31:0] o_value_out,
    input logic [2:0]  o_code_length
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("out beat dropped while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("out valid after reset");

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_code_length != 3'd0) && (o_code_length <= 3'd5))
        else $error("code length out of range");

    a_enc_no_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last_byte |-> o_value_out == 32'd0)
        else $error("encode beat carries a value");

    a_short_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last_byte && (o_code_length == 3'd1) |-> !o_byte_out[7])
        else $error("one-byte code with lead bit set");

endmodule

bind prefix_varint_codec pvc_checker u_pvc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_byte_out    (o_byte_out),
    .o_last_byte   (o_last_byte),
    .o_value_out   (o_value_out),
    .o_code_length (o_code_length)
);
